/* rtl/core/rpt_pkg.sv */
// Package: shared constants, types and codes for the rectangle placement table.
`default_nettype none

package rpt_pkg;

   // Table depth and derived widths
   localparam int MAX_RECTS = 64;
   localparam int IDX_W     = $clog2(MAX_RECTS);
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);

   // Coordinate widths
   localparam int LEFT_W   = 16;
   localparam int RIGHT_W  = 17;
   localparam int WIDTH_W  = 15;
   localparam int HEIGHT_W = 15;
   localparam int COORD_W  = 21;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int STATUS_W = 2;

   // Lowest coordinate that may be stored, at the width of p - H
   localparam logic signed [DIFF_W-1:0] COORD_MIN = -(DIFF_W'(1) <<< (COORD_W - 1));

   // Request commands
   localparam logic CMD_RESERVE = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LOW  = 2'd2;

   // One stored rectangle
   typedef struct packed {
      logic [LEFT_W-1:0]  left;
      logic [RIGHT_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic [COORD_W-1:0] top;
   } rpt_entry_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_DRAIN,
      S_CHECK,
      S_DONE
   } rpt_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;        // capture request word, seed p
      logic pass_start;  // rewind scan address, clear moved flag
      logic read;        // read entry at scan address, advance
      logic finish;      // write result word, store or clear
   } rpt_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic count_zero;
      logic last_addr;
      logic moved;
      logic out_free;
   } rpt_stat_type;

endpackage

`default_nettype wire

/* rtl/core/rpt_if.sv */
// Interfaces: request and response channels of the rectangle placement table.
`default_nettype none

interface rpt_req_if import rpt_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic signed [LEFT_W-1:0]    left_edge;
   logic        [WIDTH_W-1:0]   span_width;
   logic signed [LEFT_W-1:0]    start_bottom;
   logic        [HEIGHT_W-1:0]  box_height;

   modport source (output valid, command, left_edge, span_width, start_bottom, box_height,
                   input ready);
   modport sink   (input valid, command, left_edge, span_width, start_bottom, box_height,
                   output ready);
endinterface

interface rpt_rsp_if import rpt_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic signed [COORD_W-1:0]   placed_bottom;
   logic        [STATUS_W-1:0]  status;

   modport source (output valid, placed_bottom, status, input ready);
   modport sink   (input valid, placed_bottom, status, output ready);
endinterface

`default_nettype wire

/* rtl/core/rpt_ctrl.sv */
// Controller: sequences load, scan passes and result write-back.
`default_nettype none

module rpt_ctrl import rpt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire rpt_stat_type stat,
   output rpt_cmd_type       cmd
);

   rpt_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (stat.is_clear || stat.count_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.pass_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.read = 1'b1;
            if (stat.last_addr) begin
               state_in = S_DRAIN;
            end
         end
         // let the last read of the pass be checked
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.moved) begin
               cmd.pass_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/rpt_dpath.sv */
// Datapath: entry memory, conflict check, search position and result register.
`default_nettype none

module rpt_dpath import rpt_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rpt_cmd_type                 cmd,
   output rpt_stat_type                     stat,
   input  wire logic                        req_command,
   input  wire logic signed [LEFT_W-1:0]    req_left_edge,
   input  wire logic        [WIDTH_W-1:0]   req_span_width,
   input  wire logic signed [LEFT_W-1:0]    req_start_bottom,
   input  wire logic        [HEIGHT_W-1:0]  req_box_height,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [COORD_W-1:0]        rsp_placed_bottom,
   output logic        [STATUS_W-1:0]       rsp_status
);

   rpt_entry_type mem [MAX_RECTS];

   logic                        clear_ff;
   logic signed [LEFT_W-1:0]    left_ff;
   logic signed [RIGHT_W-1:0]   right_ff, right_in;
   logic        [HEIGHT_W-1:0]  hgt_ff;
   logic signed [COORD_W-1:0]   p_ff, p_in;
   logic                        moved_ff, moved_in;
   logic        [IDX_W-1:0]     addr_ff, addr_in;
   logic        [CNT_W-1:0]     count_ff, count_in;
   rpt_entry_type               rd_data_ff;
   logic                        rd_valid_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0]   rsp_bottom_ff, rsp_bottom_in;
   logic        [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic signed [DIFF_W-1:0]    p_less_h;
   logic                        x_ov, y_ov, hit;
   logic                        full, below, mem_we;
   rpt_entry_type               wr_entry;

   // Right edge of the incoming request
   assign right_in = $signed({req_left_edge[LEFT_W-1], req_left_edge})
                   + $signed({2'b00, req_span_width});

   // Conflict check of the entry read last cycle against current p
   always_comb begin
      p_less_h = $signed({p_ff[COORD_W-1], p_ff}) - $signed({7'b0, hgt_ff});
      x_ov = ($signed(rd_data_ff.right) > $signed({left_ff[LEFT_W-1], left_ff}))
          && (($signed({rd_data_ff.left[LEFT_W-1], rd_data_ff.left}) < right_ff)
              || ($signed(rd_data_ff.left) <= left_ff));
      y_ov = ($signed({rd_data_ff.bottom[COORD_W-1], rd_data_ff.bottom}) > p_less_h)
          && ($signed(rd_data_ff.top) < p_ff);
      hit  = rd_valid_ff && x_ov && y_ov;
   end

   // Search position, moved flag and scan address
   always_comb begin
      p_in     = p_ff;
      moved_in = moved_ff;
      addr_in  = addr_ff;
      if (cmd.load) begin
         p_in = COORD_W'(req_start_bottom);
      end else if (hit) begin
         p_in = $signed(rd_data_ff.top);
      end
      if (cmd.pass_start) begin
         moved_in = 1'b0;
         addr_in  = '0;
      end else begin
         if (hit) begin
            moved_in = 1'b1;
         end
         if (cmd.read) begin
            addr_in = addr_ff + IDX_W'(1);
         end
      end
   end

   // Result, store decision and output register
   always_comb begin
      full          = (count_ff == CNT_W'(MAX_RECTS));
      below         = (p_less_h < COORD_MIN);
      mem_we        = 1'b0;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_bottom_in = rsp_bottom_ff;
      rsp_status_in = rsp_status_ff;
      wr_entry.left   = left_ff;
      wr_entry.right  = right_ff;
      wr_entry.bottom = p_ff;
      wr_entry.top    = p_less_h[COORD_W-1:0];
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (clear_ff) begin
            count_in      = '0;
            rsp_bottom_in = '0;
            rsp_status_in = STATUS_OK;
         end else begin
            rsp_bottom_in = p_ff;
            priority if (full) begin
               rsp_status_in = STATUS_FULL;
            end else if (below) begin
               rsp_status_in = STATUS_LOW;
            end else begin
               rsp_status_in = STATUS_OK;
               mem_we        = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         moved_ff     <= 1'b0;
         addr_ff      <= '0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= cmd.read;
         moved_ff     <= moved_in;
         addr_ff      <= addr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         clear_ff <= (req_command == CMD_CLEAR);
         left_ff  <= req_left_edge;
         right_ff <= right_in;
         hgt_ff   <= req_box_height;
      end
      p_ff          <= p_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // Status to controller
   assign stat.is_clear   = clear_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.last_addr  = ((CNT_W'(addr_ff) + CNT_W'(1)) == count_ff);
   assign stat.moved      = moved_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_placed_bottom = rsp_bottom_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/core/rectangle_placement_table.sv */
// Top level: rectangle placement table, controller plus datapath.
//
//   channel   dir   handshake      word
//   req_chan  in    valid/ready    command, left_edge, span_width, start_bottom, box_height
//   rsp_chan  out   valid/ready    placed_bottom, status
//
// A clear, and a reserve on an empty table, do no scan. A reserve with n > 0
// stored entries makes k scan passes, 1 <= k <= n+1; one pass reads every
// entry once through the single read port of the entry memory. Reset empties
// the table at once (entry count to zero), with no clearing pass. A word is
// taken only while no search runs; a stalled response holds the result
// register and the finished search waits for it to drain.
`default_nettype none

module rectangle_placement_table import rpt_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   rpt_req_if.sink    req_chan,
   rpt_rsp_if.source  rsp_chan
);

   rpt_cmd_type  cmd;
   rpt_stat_type stat;

   rpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpt_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_command       (req_chan.command),
      .req_left_edge     (req_chan.left_edge),
      .req_span_width    (req_chan.span_width),
      .req_start_bottom  (req_chan.start_bottom),
      .req_box_height    (req_chan.box_height),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_placed_bottom (rsp_chan.placed_bottom),
      .rsp_status        (rsp_chan.status)
   );

endmodule

`default_nettype wire
